>>> design/prew_pkg.sv
// Shared constants, types and helpers for the Prewitt edge magnitude core.
// No dependencies; imported by prewitt_edge_magnitude_rgb_core.
`timescale 1ns / 1ps
`default_nettype none

package prew_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int NUM_CHAN = 3;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = NUM_CHAN * CHAN_W;

  localparam int COL_W  = $clog2(MAX_WIDTH);       // column position
  localparam int ROW_W  = $clog2(MAX_HEIGHT);      // row position
  localparam int WCFG_W = 11;                      // image_width register
  localparam int HCFG_W = 13;                      // image_height register

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  typedef logic [CHAN_W-1:0]     chan_t;
  typedef logic [PIX_W-1:0]      pixel_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes on the configuration port
  localparam cfg_idx_t CFG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t CFG_LOW_CUT      = 2'd2;

  localparam logic [WCFG_W-1:0] WIDTH_RESET   = 11'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET  = 13'd480;
  localparam chan_t             LOW_CUT_RESET = 8'd20;
  localparam chan_t             MAG_MAX       = 8'd255;

  // width in use, limited to [3, MAX_WIDTH]
  function automatic logic [WCFG_W-1:0] sat_width(input logic [WCFG_W-1:0] w);
    logic [WCFG_W-1:0] r;
    r = w;
    if (w < WCFG_W'(3)) r = WCFG_W'(3);
    if (w > WCFG_W'(MAX_WIDTH)) r = WCFG_W'(MAX_WIDTH);
    return r;
  endfunction

  // height in use, limited to [3, MAX_HEIGHT]
  function automatic logic [HCFG_W-1:0] sat_height(input logic [HCFG_W-1:0] h);
    logic [HCFG_W-1:0] r;
    r = h;
    if (h < HCFG_W'(3)) r = HCFG_W'(3);
    if (h > HCFG_W'(MAX_HEIGHT)) r = HCFG_W'(MAX_HEIGHT);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/prewitt_edge_magnitude_rgb_core.sv
// Prewitt edge magnitude core: line memory, 3x3 window, per-channel sqrt.
// Depends on prew_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes BGR pixels in raster order and returns, per channel, the floor square
// root of Gx^2 + Gy^2 over a 3x3 Prewitt window, clamped to 255 and forced to
// 0 below low_cut. Each result belongs to the pixel one row and one column
// behind the pixel just taken; pixels in column 0 or row 0 give no result, so
// the last row and column of a frame are never emitted. Results in the first
// row or column (and past the configured size) are 0. frame_last marks the
// final result of a frame. Both line stores live in one 1024 x 48 memory
// (upper and lower row side by side), read at the column position and written
// back once per pixel. Per pixel beat the sequencer runs IDLE and SHIFT; a
// border result then takes OUT, an interior result SUM, SQR, ROOT and OUT,
// dominated by the 8-step shift-subtract square root (all three channels run
// in parallel). A result leaves through an output register, so a stalled
// result holds the core only when the next result is ready to load. After
// reset the core clears the line memory, one entry per cycle, all 1024
// entries; pix_stall stays high during the sweep while configuration writes
// are still taken. The user must write configuration only between frames
// or while the core is idle; the core itself does not enforce this.
module prewitt_edge_magnitude_rgb_core (
  input  wire                  clk,
  input  wire                  rst,
  // pixel input channel
  input  wire                  pix_valid,
  output logic                 pix_stall,
  input  wire  prew_pkg::chan_t blue_in,
  input  wire  prew_pkg::chan_t green_in,
  input  wire  prew_pkg::chan_t red_in,
  // result channel
  output logic                 res_valid,
  input  wire                  res_stall,
  output prew_pkg::chan_t      blue_edge,
  output prew_pkg::chan_t      green_edge,
  output prew_pkg::chan_t      red_edge,
  output logic                 frame_last,
  // configuration write channel
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  prew_pkg::cfg_idx_t  cfg_index,
  input  wire  prew_pkg::cfg_data_t cfg_data
);
  import prew_pkg::*;

  localparam int MEM_W  = 2 * PIX_W;
  localparam int ABS_W  = 10;                // |G| <= 765
  localparam int SQ_W   = 2 * ABS_W + 1;     // Gx^2 + Gy^2 < 2^21
  localparam int ROOT_W = 16;                // sqrt over 16-bit remainder
  localparam int STEP_W = 3;                 // 8 sqrt steps

  localparam logic [COL_W-1:0]  CLR_LAST  = COL_W'(MAX_WIDTH - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = '1;
  localparam logic [ROOT_W-1:0] BIT_FIRST = ROOT_W'(1) << (ROOT_W - 2);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_SQR   = 3'd3;
  localparam logic [2:0] ST_ROOT  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state;

  // ---------------- configuration ----------------
  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;
  chan_t             low_cut;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      low_cut      <= LOW_CUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[WCFG_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[HCFG_W-1:0];
        CFG_LOW_CUT:      low_cut      <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WCFG_W-1:0] w_eff;
  logic [HCFG_W-1:0] h_eff;
  assign w_eff = sat_width(image_width);
  assign h_eff = sat_height(image_height);

  // ---------------- positions and input capture ----------------
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  pixel_t           pix_q;
  logic             clr_active;
  logic [COL_W-1:0] clr_addr;

  logic pix_take;
  assign pix_stall = !((state == ST_IDLE) && !clr_active);
  assign pix_take  = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (pix_take) pix_q <= {red_in, green_in, blue_in};
  end

  // position decode for the pixel in flight (valid in ST_SHIFT)
  logic [WCFG_W-1:0] col_ext;
  logic [HCFG_W-1:0] row_ext;
  logic end_row, end_frame, emit, border;
  assign col_ext   = WCFG_W'(col_pos);
  assign row_ext   = HCFG_W'(row_pos);
  assign end_row   = col_ext >= (w_eff - WCFG_W'(1));
  assign end_frame = row_ext >= (h_eff - HCFG_W'(1));
  assign emit      = (col_pos != '0) && (row_pos != '0);
  assign border    = (col_pos < COL_W'(2)) || (row_pos < ROW_W'(2)) ||
                     (col_ext >= w_eff) || (row_ext >= h_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (state == ST_SHIFT) begin
      if (end_row) begin
        col_pos <= '0;
        row_pos <= end_frame ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  // ---------------- line memory ----------------
  // entry = {upper row pixel, lower row pixel}
  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] rd_data;
  logic             mem_we;
  logic [COL_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  pixel_t           rd_up, rd_lo;

  assign rd_up     = rd_data[MEM_W-1:PIX_W];
  assign rd_lo     = rd_data[PIX_W-1:0];
  assign mem_we    = clr_active || (state == ST_SHIFT);
  assign mem_waddr = clr_active ? clr_addr : col_pos;
  assign mem_wdata = clr_active ? '0 : {rd_lo, pix_q};

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    if (state == ST_IDLE) rd_data <= line_mem[col_pos];
  end

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == CLR_LAST) clr_active <= 1'b0;
    end
  end

  // ---------------- 3x3 window ----------------
  pixel_t win [9];

  always_ff @(posedge clk) begin
    if (state == ST_SHIFT) begin
      for (int r = 0; r < 3; r++) begin
        win[3*r]   <= win[3*r+1];
        win[3*r+1] <= win[3*r+2];
      end
      win[2] <= rd_up;
      win[5] <= rd_lo;
      win[8] <= pix_q;
    end
  end

  // ---------------- per-channel arithmetic ----------------
  logic [ABS_W-1:0]  ax [NUM_CHAN];
  logic [ABS_W-1:0]  ay [NUM_CHAN];
  logic              big [NUM_CHAN];
  logic [ROOT_W-1:0] rem [NUM_CHAN];
  logic [ROOT_W-1:0] root [NUM_CHAN];
  logic [ROOT_W-1:0] sq_bit;
  logic [STEP_W-1:0] step;
  logic              last_q;

  // Prewitt sums, signed 11 bits
  logic signed [ABS_W:0] gx [NUM_CHAN];
  logic signed [ABS_W:0] gy [NUM_CHAN];
  logic [SQ_W-1:0]       sq [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      gx[c] = (ABS_W+1)'(win[6][CHAN_W*c +: CHAN_W]) + (ABS_W+1)'(win[7][CHAN_W*c +: CHAN_W])
            + (ABS_W+1)'(win[8][CHAN_W*c +: CHAN_W]) - (ABS_W+1)'(win[0][CHAN_W*c +: CHAN_W])
            - (ABS_W+1)'(win[1][CHAN_W*c +: CHAN_W]) - (ABS_W+1)'(win[2][CHAN_W*c +: CHAN_W]);
      gy[c] = (ABS_W+1)'(win[0][CHAN_W*c +: CHAN_W]) + (ABS_W+1)'(win[3][CHAN_W*c +: CHAN_W])
            + (ABS_W+1)'(win[6][CHAN_W*c +: CHAN_W]) - (ABS_W+1)'(win[2][CHAN_W*c +: CHAN_W])
            - (ABS_W+1)'(win[5][CHAN_W*c +: CHAN_W]) - (ABS_W+1)'(win[8][CHAN_W*c +: CHAN_W]);
      sq[c] = SQ_W'(ax[c] * ax[c]) + SQ_W'(ay[c] * ay[c]);
    end
  end

  // one shift-subtract square root step per channel
  logic [ROOT_W:0]   trial [NUM_CHAN];
  logic              fits [NUM_CHAN];
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      trial[c] = {1'b0, root[c]} + {1'b0, sq_bit};
      fits[c]  = {1'b0, rem[c]} >= trial[c];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_SHIFT: begin
        // border result: zero magnitude
        last_q <= end_row && end_frame;
        for (int c = 0; c < NUM_CHAN; c++) begin
          big[c]  <= 1'b0;
          root[c] <= '0;
        end
      end
      ST_SUM: begin
        for (int c = 0; c < NUM_CHAN; c++) begin
          ax[c] <= gx[c][ABS_W] ? ABS_W'(-gx[c]) : gx[c][ABS_W-1:0];
          ay[c] <= gy[c][ABS_W] ? ABS_W'(-gy[c]) : gy[c][ABS_W-1:0];
        end
      end
      ST_SQR: begin
        sq_bit <= BIT_FIRST;
        step   <= '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
          big[c]  <= sq[c][SQ_W-1:ROOT_W] != '0;   // root >= 256, clamps
          rem[c]  <= sq[c][ROOT_W-1:0];
          root[c] <= '0;
        end
      end
      ST_ROOT: begin
        sq_bit <= sq_bit >> 2;
        step   <= step + STEP_W'(1);
        for (int c = 0; c < NUM_CHAN; c++) begin
          if (fits[c]) begin
            rem[c]  <= rem[c] - trial[c][ROOT_W-1:0];
            root[c] <= (root[c] >> 1) + sq_bit;
          end else begin
            root[c] <= root[c] >> 1;
          end
        end
      end
      default: ;
    endcase
  end

  // clamp and low cut
  chan_t mag [NUM_CHAN];
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      mag[c] = big[c] ? MAG_MAX : root[c][CHAN_W-1:0];
      if (mag[c] < low_cut) mag[c] = '0;
    end
  end

  // ---------------- output register ----------------
  logic out_free, out_load;
  assign out_free = !res_valid || !res_stall;
  assign out_load = (state == ST_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      blue_edge  <= mag[0];
      green_edge <= mag[1];
      red_edge   <= mag[2];
      frame_last <= last_q;
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE:  if (pix_take) state <= ST_SHIFT;
        ST_SHIFT: begin
          if (!emit)       state <= ST_IDLE;
          else if (border) state <= ST_OUT;
          else             state <= ST_SUM;
        end
        ST_SUM:   state <= ST_SQR;
        ST_SQR:   state <= ST_ROOT;
        ST_ROOT:  if (step == STEP_LAST) state <= ST_OUT;
        ST_OUT:   if (out_free) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    pix_take |-> !clr_active)
    else $error("pixel taken during line memory clear");

  a_take_starts_item: assert property (@(posedge clk) disable iff (rst)
    pix_take |=> (state == ST_SHIFT))
    else $error("accepted pixel did not start processing");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == ST_OUT))
    else $error("result appeared outside the output step");

  a_root_bit_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT) |-> (sq_bit != '0))
    else $error("square root ran past its last step");

endmodule

`default_nettype wire

>>> tb/prewitt_edge_magnitude_rgb_checker.sv
`timescale 1ns / 1ps
// Watches the pixel, result and config channels of the Prewitt edge core,
// predicts every result beat and compares it field by field.
// Depends on prew_pkg.
module prewitt_edge_magnitude_rgb_checker (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 pix_valid,
  input  wire                 pix_stall,
  input  prew_pkg::chan_t     blue_in,
  input  prew_pkg::chan_t     green_in,
  input  prew_pkg::chan_t     red_in,
  input  wire                 res_valid,
  input  wire                 res_stall,
  input  prew_pkg::chan_t     blue_edge,
  input  prew_pkg::chan_t     green_edge,
  input  prew_pkg::chan_t     red_edge,
  input  wire                 frame_last,
  input  wire                 cfg_valid,
  input  wire                 cfg_ready,
  input  prew_pkg::cfg_idx_t  cfg_index,
  input  prew_pkg::cfg_data_t cfg_data,
  output int                  mismatches,
  output int                  edges_pending
);
  import prew_pkg::*;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
    logic  last;
  } edge_beat_t;

  edge_beat_t edge_queue[$];

  logic [WCFG_W-1:0] width_reg;
  logic [HCFG_W-1:0] height_reg;
  chan_t             cut_reg;

  pixel_t      upper_row [MAX_WIDTH];
  pixel_t      lower_row [MAX_WIDTH];
  pixel_t      nbhd [9];     // 3x3 window, row major, oldest column first
  int unsigned col_pos;
  int unsigned row_pos;

  // bit-by-bit floor square root; 2 * 765^2 fits well below 2^24
  function automatic int unsigned int_sqrt(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic chan_t channel_edge(input int sh);
    int          gx;
    int          gy;
    int unsigned mag;
    gx = 0;
    gy = 0;
    for (int k = 0; k < 3; k++) begin
      gx += int'(nbhd[6+k][sh +: 8]) - int'(nbhd[k][sh +: 8]);
      gy += int'(nbhd[3*k][sh +: 8]) - int'(nbhd[3*k+2][sh +: 8]);
    end
    mag = int_sqrt(gx * gx + gy * gy);
    if (mag > 255) mag = 255;
    if (mag < cut_reg) mag = 0;
    return chan_t'(mag);
  endfunction

  function automatic void absorb_pixel(input chan_t b, input chan_t g, input chan_t r);
    int unsigned w;
    int unsigned h;
    pixel_t      pix;
    pixel_t      up;
    pixel_t      lo;
    logic        border;
    edge_beat_t  beat;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    pix = {r, g, b};
    up = upper_row[col_pos];
    lo = lower_row[col_pos];
    upper_row[col_pos] = lo;
    lower_row[col_pos] = pix;
    for (int i = 0; i < 3; i++) begin
      nbhd[3*i]   = nbhd[3*i+1];
      nbhd[3*i+1] = nbhd[3*i+2];
    end
    nbhd[2] = up;
    nbhd[5] = lo;
    nbhd[8] = pix;
    if (col_pos >= 1 && row_pos >= 1) begin
      border     = (col_pos < 2) || (row_pos < 2) || (col_pos >= w) || (row_pos >= h);
      beat.blue  = border ? '0 : channel_edge(0);
      beat.green = border ? '0 : channel_edge(8);
      beat.red   = border ? '0 : channel_edge(16);
      beat.last  = (col_pos >= w - 1) && (row_pos >= h - 1);
      edge_queue.push_back(beat);
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    edge_beat_t want;
    if (rst) begin
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      cut_reg    = LOW_CUT_RESET;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
      for (int i = 0; i < 9; i++) nbhd[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      edge_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_data[WCFG_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HCFG_W-1:0];
          CFG_LOW_CUT:      cut_reg    = cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end
      // pop before push: a result never belongs to the pixel of the same edge
      if (res_valid && !res_stall) begin
        if (edge_queue.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual b=%0d g=%0d r=%0d last=%0d",
                   $time, blue_edge, green_edge, red_edge, frame_last);
          mismatches++;
        end else begin
          want = edge_queue.pop_front();
          check_field("blue_edge", want.blue, blue_edge);
          check_field("green_edge", want.green, green_edge);
          check_field("red_edge", want.red, red_edge);
          check_field("frame_last", want.last, frame_last);
        end
      end
      if (pix_valid && !pix_stall) absorb_pixel(blue_in, green_in, red_in);
    end
    edges_pending = edge_queue.size();
  end

endmodule

>>> tb/prewitt_edge_magnitude_rgb_core_test.sv
`timescale 1ns / 1ps
// Testbench top for prewitt_edge_magnitude_rgb_core: directed frames, then
// random frames under random gaps and stalls, with a checker beside the core.
// Depends on prew_pkg, the core and prewitt_edge_magnitude_rgb_checker.
module prewitt_edge_magnitude_rgb_core_test;
  import prew_pkg::*;

  // index 3 decodes to no register; writes there must be harmless
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  localparam int RANDOM_PIXELS = 550;
  // a pixel that yields no result only passes SHIFT; this leaves plenty of margin
  localparam int SETTLE_CYCLES = 20;
  // quiet cycles allowed: covers the line clear after reset,
  // an interior beat and both sides' longest waits many times over
  localparam int QUIET_LIMIT = 5000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      pix_valid = 1'b0;
  logic      pix_stall;
  chan_t     blue_in = '0;
  chan_t     green_in = '0;
  chan_t     red_in = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  chan_t     blue_edge;
  chan_t     green_edge;
  chan_t     red_edge;
  logic      frame_last;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = CFG_IMAGE_WIDTH;
  cfg_data_t cfg_data = '0;

  int mismatches;
  int edges_pending;
  int quiet_cycles = 0;

  // per-phase switches: when set, that side runs back to back with no idling
  logic pix_burst = 1'b0;
  logic res_burst = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  prewitt_edge_magnitude_rgb_core dut (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .blue_in    (blue_in),
    .green_in   (green_in),
    .red_in     (red_in),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .blue_edge  (blue_edge),
    .green_edge (green_edge),
    .red_edge   (red_edge),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  prewitt_edge_magnitude_rgb_checker edge_check (
    .clk           (clk),
    .rst           (rst),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .blue_in       (blue_in),
    .green_in      (green_in),
    .red_in        (red_in),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .blue_edge     (blue_edge),
    .green_edge    (green_edge),
    .red_edge      (red_edge),
    .frame_last    (frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .edges_pending (edges_pending)
  );

  // One register write; the beat lands at the first edge with ready high.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One pixel beat. Valid stays high after acceptance so that a zero gap
  // gives back-to-back beats; close_pixels drops it at the end of a batch.
  task automatic push_pixel(input chan_t b, input chan_t g, input chan_t r);
    int gap;
    gap = pix_burst ? 0 : $urandom_range(0, 14);
    @(negedge clk);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    blue_in   <= b;
    green_in  <= g;
    red_in    <= r;
    do @(posedge clk); while (pix_stall);
  endtask

  // Must follow the last push_pixel of a batch directly, or the held beat
  // would be taken again.
  task automatic close_pixels();
    @(negedge clk);
    pix_valid <= 1'b0;
  endtask

  // Idle point: every expected beat has arrived and any pixel that yields no
  // result has had time to leave the pipe.
  task automatic wait_idle();
    while (edges_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: before each beat draw a random stall, none in a result burst.
  initial begin : result_drain
    int hold;
    forever begin
      hold = res_burst ? 0 : $urandom_range(0, 14);
      @(negedge clk);
      if (hold > 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!(res_valid && !res_stall));
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (pix_valid && !pix_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int    sent;
    int    count;
    int    mode;
    int    base_level;
    chan_t px [3];

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Sizes below range saturate to the 3x3 minimum; cut at its floor.
    // Writes go in while the core clears its line memory.
    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    write_reg(CFG_IMAGE_HEIGHT, 13'd2);
    write_reg(CFG_LOW_CUT, 13'd0);
    write_reg(CFG_UNUSED, 13'h1FFF);

    // Two 3x3 frames: four results each, three on the border, the last one
    // interior and flagged frame_last. First frame: blue steps to 255 in
    // the last column, green falls from 255 after the top row, red flat, so
    // blue and green clamp at 255 and red is 0. Second frame mirrors the
    // steps (opposite signs) with the cut at 255; red is a gentle ramp that
    // the cut forces to 0, while the clamped channels still pass.
    for (int f = 0; f < 2; f++) begin
      if (f == 1) begin
        wait_idle();
        write_reg(CFG_LOW_CUT, 13'h1FFF);   // upper bits dropped: cut = 255
      end
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          if (f == 0) begin
            push_pixel((x == 2) ? 8'd255 : 8'd0, (y == 0) ? 8'd255 : 8'd0, 8'd128);
          end else begin
            push_pixel((x == 2) ? 8'd0 : 8'd255, (y == 2) ? 8'd255 : 8'd0,
                       chan_t'(10 * (x + y)));
          end
        end
      end
      close_pixels();
    end

    // Sizes above range saturate to the maximum; a short partial row follows.
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 13'h17FF);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    for (int i = 0; i < 4; i++) push_pixel((i % 2) ? 8'd255 : 8'd0, 8'd255, 8'd0);
    close_pixels();

    // Width shrinks mid-row: column 4 is already past the new end, so the
    // next pixel closes the row at once.
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 13'h1803);   // upper bits dropped: width = 3
    push_pixel(8'd17, 8'd34, 8'd51);
    push_pixel(8'd200, 8'd100, 8'd50);
    close_pixels();
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 13'd1);

    // ---- random part ----
    // Each batch: maybe resize, maybe move the cut, then a run of pixels.
    // Size changes are rare enough that most frames run through whole.
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      wait_idle();
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_IMAGE_WIDTH, cfg_data_t'($urandom_range(0, 2)));
          1:       write_reg(CFG_IMAGE_WIDTH, cfg_data_t'($urandom_range(1020, 2047)));
          2:       write_reg(CFG_IMAGE_WIDTH, cfg_data_t'($urandom));
          default: write_reg(CFG_IMAGE_WIDTH, cfg_data_t'($urandom_range(3, 10)));
        endcase
      end
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 9))
          0:       write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'($urandom_range(0, 2)));
          1:       write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'($urandom_range(4090, 8191)));
          2:       write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'($urandom));
          default: write_reg(CFG_IMAGE_HEIGHT, cfg_data_t'($urandom_range(3, 8)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       write_reg(CFG_LOW_CUT, 13'd0);
          1:       write_reg(CFG_LOW_CUT, 13'd255);
          2:       write_reg(CFG_LOW_CUT, cfg_data_t'($urandom));
          default: write_reg(CFG_LOW_CUT, cfg_data_t'($urandom_range(0, 120)));
        endcase
      end
      pix_burst  = ($urandom_range(0, 3) == 0);
      res_burst  = ($urandom_range(0, 3) == 0);
      // content: full noise, hard 0/255 steps, or a smooth patch whose small
      // gradients sit near the cut
      mode       = $urandom_range(0, 2);
      base_level = $urandom_range(0, 240);
      count      = $urandom_range(1, 60);
      repeat (count) begin
        for (int c = 0; c < 3; c++) begin
          case (mode)
            0:       px[c] = chan_t'($urandom_range(0, 255));
            1:       px[c] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default: px[c] = chan_t'(base_level + $urandom_range(0, 15));
          endcase
        end
        push_pixel(px[0], px[1], px[2]);
      end
      close_pixels();
      sent += count;
    end

    // drain, let the last pixel clear the pipe, then the verdict
    wait_idle();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
